// ----- design/ligp_pkg.sv -----
// Package for the longest increasing grid path block.
// Holds the state encoding, the length type, the neighbor codes and the register indexes.
package ligp_pkg;

  localparam int unsigned LenW = 13;

  localparam logic CfgRows = 1'b0;
  localparam logic CfgCols = 1'b1;

  typedef logic [LenW-1:0] len_t;

  typedef enum logic [1:0] {
    DirUp    = 2'd0,
    DirRight = 2'd1,
    DirDown  = 2'd2,
    DirLeft  = 2'd3
  } dir_e;

  typedef enum logic [3:0] {
    StLoad,
    StClear,
    StStart,
    StStartWait,
    StTop,
    StCellWait,
    StNbRead,
    StNbWait,
    StNbCheck,
    StPop,
    StNext,
    StOut
  } state_e;

endpackage

// ----- design/ligp_mem.sv -----
// Generic single-port-write, single-read synchronous memory with registered read data.
// Used for the grid, memo and stack stores; depends on nothing else.
module ligp_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- design/longest_increasing_grid_path_top.sv -----
// Longest increasing grid path: loads one element per cycle, then searches.
// After the last transfer the MAX_ROWS*MAX_COLS memo entries are cleared; for each start
// cell its memo entry is read; a visit reads the stack top, checks each in-grid neighbor,
// skips off-grid directions and pops; the result then waits while out_stall_i is high.
// Throughput: one element per cycle while loading; input stalls until the result transfer.
// Reset clears control state and sets both dimensions to one; depends on ligp_pkg, ligp_mem.
module longest_increasing_grid_path_top #(
  parameter int unsigned MAX_ROWS = 64,
  parameter int unsigned MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] cell_value_i,
  input  logic        last_cell_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [12:0] path_length_o
);
  import ligp_pkg::*;

  localparam int unsigned Cap = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW  = (Cap > 1) ? $clog2(Cap) : 1;
  localparam int unsigned RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned SW  = AW + 1;
  localparam int unsigned SDW = RW + CW;
  localparam int unsigned PW  = AW + 10;

  // Flat row-major address of a cell.
  function automatic logic [AW-1:0] cell_addr(logic [RW-1:0] r, logic [CW-1:0] c,
                                              logic [8:0] w);
    logic [PW-1:0] prod;
    prod = PW'(r) * PW'(w) + PW'(c);
    return prod[AW-1:0];
  endfunction

  state_e state_q, state_d;
  logic [6:0] rows_cfg_q, cols_cfg_q;
  logic [8:0] rows, cols;
  logic [17:0] n_full;
  logic [AW:0] n_cells, load_q, load_d, start_q, start_d;
  logic [SW-1:0] sp_q, sp_d;
  logic [RW-1:0] r_q, r_d, cr_q, cr_d;
  logic [CW-1:0] c_q, c_d, cc_q, cc_d;
  dir_e dir_q, dir_d;
  len_t longest_q, longest_d, best_q, best_d;
  logic [31:0] cell_val_q, cell_val_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [SDW-1:0] nb_q, nb_d;
  logic nb_ok;
  logic [RW:0] nr;
  logic [CW:0] nc;

  logic g_we; logic [AW-1:0] g_wa, g_ra; logic [31:0] g_wd, g_rd;
  logic m_we; logic [AW-1:0] m_wa, m_ra; len_t m_wd, m_rd;
  logic s_we; logic [AW-1:0] s_wa, s_ra; logic [SDW-1:0] s_wd, s_rd;

  ligp_mem #(.Depth(Cap), .Width(32)) u_grid (.clk_i, .we_i(g_we), .waddr_i(g_wa),
    .wdata_i(g_wd), .raddr_i(g_ra), .rdata_o(g_rd));
  ligp_mem #(.Depth(Cap), .Width(LenW)) u_memo (.clk_i, .we_i(m_we), .waddr_i(m_wa),
    .wdata_i(m_wd), .raddr_i(m_ra), .rdata_o(m_rd));
  // Stack entries hold the row and column of a cell.
  ligp_mem #(.Depth(Cap), .Width(SDW)) u_stack (.clk_i, .we_i(s_we), .waddr_i(s_wa),
    .wdata_i(s_wd), .raddr_i(s_ra), .rdata_o(s_rd));

  always_comb begin
    rows = (rows_cfg_q == 7'd0) ? 9'd1 :
           ({2'b0, rows_cfg_q} > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : {2'b0, rows_cfg_q};
    cols = (cols_cfg_q == 7'd0) ? 9'd1 :
           ({2'b0, cols_cfg_q} > 9'(MAX_COLS)) ? 9'(MAX_COLS) : {2'b0, cols_cfg_q};
  end
  assign n_full  = 18'(rows) * 18'(cols);
  assign n_cells = n_full[AW:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_cfg_q <= 7'd1;
      cols_cfg_q <= 7'd1;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CfgRows) rows_cfg_q <= cfg_data_i;
      else cols_cfg_q <= cfg_data_i;
    end
  end

  // Neighbor coordinates of the current cell for the direction under test.
  always_comb begin
    nr = {1'b0, cr_q};
    nc = {1'b0, cc_q};
    nb_ok = 1'b1;
    unique case (dir_q)
      DirUp: begin
        nb_ok = (cr_q != '0);
        nr = {1'b0, cr_q} - 1'b1;
      end
      DirRight: begin
        nc = {1'b0, cc_q} + 1'b1;
        nb_ok = (9'(nc) < cols);
      end
      DirDown: begin
        nr = {1'b0, cr_q} + 1'b1;
        nb_ok = (9'(nr) < rows);
      end
      DirLeft: begin
        nb_ok = (cc_q != '0);
        nc = {1'b0, cc_q} - 1'b1;
      end
      default: nb_ok = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      load_q  <= '0;
      start_q <= '0;
      sp_q    <= '0;
      r_q <= '0; c_q <= '0; cr_q <= '0; cc_q <= '0;
      dir_q <= DirUp;
      best_q <= '0;
      clr_q <= '0;
    end else begin
      state_q <= state_d;
      load_q  <= load_d;
      start_q <= start_d;
      sp_q    <= sp_d;
      r_q <= r_d; c_q <= c_d; cr_q <= cr_d; cc_q <= cc_d;
      dir_q <= dir_d;
      best_q <= best_d;
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    longest_q  <= longest_d;
    cell_val_q <= cell_val_d;
    nb_q       <= nb_d;
  end

  always_comb begin
    state_d = state_q;
    load_d = load_q; start_d = start_q; sp_d = sp_q;
    r_d = r_q; c_d = c_q; cr_d = cr_q; cc_d = cc_q; dir_d = dir_q;
    best_d = best_q; clr_d = clr_q;
    longest_d = longest_q; cell_val_d = cell_val_q; nb_d = nb_q;
    g_we = 1'b0; g_wa = load_q[AW-1:0]; g_wd = cell_value_i;
    g_ra = cell_addr(cr_q, cc_q, cols);
    m_we = 1'b0; m_wa = cell_addr(cr_q, cc_q, cols); m_wd = '0;
    m_ra = cell_addr(cr_q, cc_q, cols);
    s_we = 1'b0; s_wa = sp_q[AW-1:0]; s_wd = {cr_q, cc_q};
    s_ra = AW'(sp_q - 1'b1);
    in_stall_o = 1'b1;
    out_valid_o = 1'b0;
    unique case (state_q)
      StLoad: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          if (load_q < n_cells) begin
            g_we = 1'b1;
            load_d = load_q + 1'b1;
          end
          if (last_cell_i) begin
            clr_d = '0;
            state_d = StClear;
          end
        end
      end
      StClear: begin
        m_we = 1'b1; m_wa = clr_q; m_wd = '0;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(Cap - 1)) begin
          start_d = '0; r_d = '0; c_d = '0; best_d = '0; sp_d = '0;
          state_d = StStart;
        end
      end
      StStart: begin
        m_ra = cell_addr(r_q, c_q, cols);
        state_d = StStartWait;
      end
      StStartWait: begin
        if (m_rd == '0) begin
          s_we = 1'b1; s_wa = '0; s_wd = {r_q, c_q};
          sp_d = SW'(1);
          state_d = StTop;
        end else begin
          if (m_rd > best_q) best_d = m_rd;
          state_d = StNext;
        end
      end
      StTop: begin
        // Read the stack top; the write of the previous cycle has landed.
        s_ra = AW'(sp_q - 1'b1);
        state_d = StCellWait;
      end
      StCellWait: begin
        cr_d = s_rd[SDW-1:CW];
        cc_d = s_rd[CW-1:0];
        dir_d = DirUp;
        longest_d = '0;
        g_ra = cell_addr(s_rd[SDW-1:CW], s_rd[CW-1:0], cols);
        state_d = StNbRead;
      end
      StNbRead: begin
        if (dir_q == DirUp) cell_val_d = g_rd;
        if (!nb_ok) begin
          state_d = (dir_q == DirLeft) ? StPop : StNbRead;
          dir_d = dir_e'(dir_q + 1'b1);
        end else begin
          nb_d = {nr[RW-1:0], nc[CW-1:0]};
          g_ra = cell_addr(nr[RW-1:0], nc[CW-1:0], cols);
          m_ra = cell_addr(nr[RW-1:0], nc[CW-1:0], cols);
          state_d = StNbWait;
        end
      end
      StNbWait: begin
        // Keep the neighbor address so the read data stays valid for the check.
        g_ra = cell_addr(nb_q[SDW-1:CW], nb_q[CW-1:0], cols);
        m_ra = cell_addr(nb_q[SDW-1:CW], nb_q[CW-1:0], cols);
        state_d = StNbCheck;
      end
      StNbCheck: begin
        if ($signed(g_rd) > $signed(cell_val_q)) begin
          if (m_rd == '0) begin
            if (sp_q < SW'(Cap)) begin
              s_we = 1'b1; s_wa = sp_q[AW-1:0]; s_wd = nb_q;
              sp_d = sp_q + 1'b1;
            end
            state_d = StTop;
          end else begin
            if (m_rd > longest_q) longest_d = m_rd;
            dir_d = dir_e'(dir_q + 1'b1);
            state_d = (dir_q == DirLeft) ? StPop : StNbRead;
          end
        end else begin
          dir_d = dir_e'(dir_q + 1'b1);
          state_d = (dir_q == DirLeft) ? StPop : StNbRead;
        end
      end
      StPop: begin
        m_we = 1'b1; m_wa = cell_addr(cr_q, cc_q, cols); m_wd = longest_q + 1'b1;
        sp_d = sp_q - 1'b1;
        if (sp_q == SW'(1)) begin
          if ((longest_q + 1'b1) > best_q) best_d = longest_q + 1'b1;
          state_d = StNext;
        end else begin
          state_d = StTop;
        end
      end
      StNext: begin
        start_d = start_q + 1'b1;
        if (9'(c_q) == cols - 9'd1) begin
          c_d = '0; r_d = r_q + 1'b1;
        end else begin
          c_d = c_q + 1'b1;
        end
        state_d = (start_q + 1'b1 >= n_cells) ? StOut : StStart;
      end
      StOut: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          load_d = '0;
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  assign path_length_o = best_q;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StLoad) |-> in_stall_o) else $error("input taken while busy");
  a_sp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SW'(Cap)) else $error("stack pointer overflow");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(path_length_o)))
    else $error("result dropped");
`endif

endmodule
